// ===== hw/rtl/wtc_pkg.sv =====
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared types and constants of the window threshold classifier.
// ----------------------------------------------------------------------------
package wtc_pkg;

	localparam int COORD_W   = 8;
	localparam int SAMPLE_W  = 16;
	localparam int ENTRY_W   = SAMPLE_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int RADIUS_W  = 3;
	localparam int MIN_CNT_W = 8;
	localparam int GRID_W    = 9;
	localparam int CRD_W     = 10;

	typedef enum logic {
		CMD_LOAD     = 1'b0,
		CMD_CLASSIFY = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		CLS_FALSE   = 2'd0,
		CLS_RELAXED = 2'd1,
		CLS_TRUE    = 2'd2,
		CLS_MISSING = 2'd3
	} point_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LO_BOUND        = 3'd0,
		REG_HI_BOUND        = 3'd1,
		REG_RELAX_RADIUS    = 3'd2,
		REG_RELAX_MIN_COUNT = 3'd3,
		REG_CENTRE_OVERRIDE = 3'd4,
		REG_GRID_WIDTH      = 3'd5,
		REG_GRID_HEIGHT     = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] lo_bound;
		logic signed [SAMPLE_W-1:0] hi_bound;
		logic [RADIUS_W-1:0]        relax_radius;
		logic [MIN_CNT_W-1:0]       relax_min_count;
		logic                       true_if_centre_in_range;
		logic [GRID_W-1:0]          grid_width;
		logic [GRID_W-1:0]          grid_height;
	} cfg_t;

endpackage

// ===== hw/rtl/wtc_item_if.sv =====
// ----------------------------------------------------------------------------
// wtc_item_if
// Input item channel: load or classify command with point and sample.
// ----------------------------------------------------------------------------
interface wtc_item_if import wtc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [COORD_W-1:0]         col;
	logic [COORD_W-1:0]         row;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       sample_invalid;

	modport source(output valid, command, col, row, sample, sample_invalid, input ready);
	modport sink(input valid, command, col, row, sample, sample_invalid, output ready);
endinterface

// ===== hw/rtl/wtc_result_if.sv =====
// ----------------------------------------------------------------------------
// wtc_result_if
// Result channel: class of one point with its coordinates.
// ----------------------------------------------------------------------------
interface wtc_result_if import wtc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         point_class;
	logic [COORD_W-1:0] class_col;
	logic [COORD_W-1:0] class_row;

	modport source(output valid, point_class, class_col, class_row, input ready);
	modport sink(input valid, point_class, class_col, class_row, output ready);
endinterface

// ===== hw/rtl/wtc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wtc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wtc_cfg_if import wtc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wtc_ram.sv =====
// ----------------------------------------------------------------------------
// wtc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wtc_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65536
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/wtc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wtc_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module wtc_cfg_regs import wtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	wtc_cfg_if.sink   wr,
	output cfg_t      cfg
);
	cfg_t regs_q;

	assign wr.ready = 1'b1;
	assign cfg      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lo_bound                <= '0;
			regs_q.hi_bound                <= 16'sh7FFF;
			regs_q.relax_radius            <= '0;
			regs_q.relax_min_count         <= MIN_CNT_W'(1);
			regs_q.true_if_centre_in_range <= 1'b0;
			regs_q.grid_width              <= GRID_W'(256);
			regs_q.grid_height             <= GRID_W'(256);
		end else if (wr.valid) begin
			case (cfg_idx_t'(wr.index))
				REG_LO_BOUND:        regs_q.lo_bound <= $signed(wr.data);
				REG_HI_BOUND:        regs_q.hi_bound <= $signed(wr.data);
				REG_RELAX_RADIUS:    regs_q.relax_radius <= wr.data[RADIUS_W-1:0];
				REG_RELAX_MIN_COUNT: regs_q.relax_min_count <= wr.data[MIN_CNT_W-1:0];
				REG_CENTRE_OVERRIDE: regs_q.true_if_centre_in_range <= wr.data[0];
				REG_GRID_WIDTH:      regs_q.grid_width <= wr.data[GRID_W-1:0];
				REG_GRID_HEIGHT:     regs_q.grid_height <= wr.data[GRID_W-1:0];
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/wtc_scan.sv =====
// ----------------------------------------------------------------------------
// wtc_scan
// Load path and window scan sequencer: walks the window over the sample
// store one window place per cycle, reading in-grid places, counts in-range
// and missing places, decides the class and holds it in the output register.
// ----------------------------------------------------------------------------
module wtc_scan import wtc_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 7,
	parameter int AW         = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	wtc_item_if.sink          item,
	wtc_result_if.source      result,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [ENTRY_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr,
	input  logic [ENTRY_W-1:0] ram_rdata
);
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DW    = (MAX_RADIUS > 0) ? $clog2(2 * MAX_RADIUS + 1) : 1;
	localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
	localparam int CMP_W = (CNT_W > MIN_CNT_W) ? CNT_W : MIN_CNT_W;
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic logic in_limits(input logic signed [SAMPLE_W-1:0] v,
		input logic signed [SAMPLE_W-1:0] lo, input logic signed [SAMPLE_W-1:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	state_t               state_q;
	logic [DW-1:0]        r_q, last_q, dx_q, dy_q;
	logic [COORD_W-1:0]   col_q, row_q;
	logic [GRID_W-1:0]    nx_q, ny_q;
	logic [CNT_W-1:0]     wsize_q, found_q, missing_q;
	logic                 act_s1, grid_s1, ctr_s1;
	logic                 ctr_grid_q, ctr_inr_q;
	logic                 out_valid_q;
	point_class_t         out_class_q;
	logic [COORD_W-1:0]   out_col_q, out_row_q;

	logic                 accept, start, out_free;
	logic [DW-1:0]        r_next, side_next;
	logic [GRID_W-1:0]    nx_next, ny_next;
	logic signed [CRD_W-1:0] x, y;
	logic                 x_in, y_in, grid_now, ctr_now, last_now, row_end;
	logic                 load_ok, value_inr;
	point_class_t         cls;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign start      = accept && (command_t'(item.command) == CMD_CLASSIFY);
	assign out_free   = !out_valid_q || result.ready;

	// load path
	assign load_ok   = (32'(item.col) < MAX_WIDTH) && (32'(item.row) < MAX_HEIGHT);
	assign ram_we    = accept && (command_t'(item.command) == CMD_LOAD) && load_ok;
	assign ram_waddr = {RW'(item.row), CW'(item.col)};
	assign ram_wdata = {item.sample_invalid, item.sample};

	// window setup, radius and grid saturate to the build limits
	assign r_next    = (32'(cfg.relax_radius) > MAX_RADIUS) ? DW'(MAX_RADIUS)
	                                                        : DW'(cfg.relax_radius);
	assign side_next = DW'({r_next, 1'b0}) + DW'(1);
	assign nx_next   = (32'(cfg.grid_width) > MAX_WIDTH) ? GRID_W'(MAX_WIDTH)
	                                                     : cfg.grid_width;
	assign ny_next   = (32'(cfg.grid_height) > MAX_HEIGHT) ? GRID_W'(MAX_HEIGHT)
	                                                       : cfg.grid_height;

	// current window place
	assign x = $signed({2'b00, col_q}) - $signed(CRD_W'(r_q)) + $signed(CRD_W'(dx_q));
	assign y = $signed({2'b00, row_q}) - $signed(CRD_W'(r_q)) + $signed(CRD_W'(dy_q));
	assign x_in     = !x[CRD_W-1] && (x[GRID_W-1:0] < nx_q);
	assign y_in     = !y[CRD_W-1] && (y[GRID_W-1:0] < ny_q);
	assign grid_now = x_in && y_in;
	assign ctr_now  = (dx_q == r_q) && (dy_q == r_q);
	assign row_end  = (dx_q == last_q);
	assign last_now = row_end && (dy_q == last_q);

	assign ram_re    = (state_q == ST_SCAN) && grid_now;
	assign ram_raddr = {RW'(y[GRID_W-1:0]), CW'(x[GRID_W-1:0])};

	assign value_inr = in_limits(ram_rdata[SAMPLE_W-1:0], cfg.lo_bound, cfg.hi_bound);

	always_comb begin
		cls = CLS_FALSE;
		if (found_q == wsize_q) begin
			cls = CLS_TRUE;
		end else if (CMP_W'(found_q) >= CMP_W'(cfg.relax_min_count)) begin
			cls = CLS_RELAXED;
		end
		if (missing_q == wsize_q) begin
			cls = CLS_MISSING;
		end
		if (cfg.true_if_centre_in_range && ctr_grid_q && ctr_inr_q) begin
			cls = CLS_TRUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			act_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_now) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		grid_s1 <= grid_now;
		ctr_s1  <= ctr_now;
		if (start) begin
			r_q        <= r_next;
			last_q     <= DW'({r_next, 1'b0});
			wsize_q    <= CNT_W'(side_next) * CNT_W'(side_next);
			col_q      <= item.col;
			row_q      <= item.row;
			nx_q       <= nx_next;
			ny_q       <= ny_next;
			dx_q       <= '0;
			dy_q       <= '0;
			found_q    <= '0;
			missing_q  <= '0;
			ctr_grid_q <= 1'b0;
			ctr_inr_q  <= 1'b0;
		end else begin
			if (state_q == ST_SCAN && !last_now) begin
				if (row_end) begin
					dx_q <= '0;
					dy_q <= dy_q + DW'(1);
				end else begin
					dx_q <= dx_q + DW'(1);
				end
			end
			if (act_s1) begin
				if (!grid_s1 || ram_rdata[ENTRY_W-1]) begin
					missing_q <= missing_q + CNT_W'(1);
				end else if (value_inr) begin
					found_q <= found_q + CNT_W'(1);
				end
				if (ctr_s1) begin
					ctr_grid_q <= grid_s1;
					ctr_inr_q  <= grid_s1 && value_inr;
				end
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_class_q <= cls;
			out_col_q   <= col_q;
			out_row_q   <= row_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.point_class = out_class_q;
	assign result.class_col   = out_col_q;
	assign result.class_row   = out_row_q;

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_IDLE)
		else $error("store written during a window scan");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> SUM_W'(found_q) + SUM_W'(missing_q) <= SUM_W'(wsize_q))
		else $error("window counts exceed window size");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside decision state");

	a_drain_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q == ST_SCAN) && !act_s1 == 1'b0)
		else $error("drain entered without a scan");
endmodule

// ===== hw/rtl/window_threshold_classifier_top.sv =====
// ----------------------------------------------------------------------------
// window_threshold_classifier_top
// Sample plane store with windowed threshold classification of points.
// ----------------------------------------------------------------------------
// Load: the next item can be taken in the following cycle.
// Classify: the scan visits one window place per cycle through the sample
//   store's single read port, then passes the DRAIN and DONE states; no new
//   item is taken until the class has been written to the result register.
// Reset clears control and configuration only; the sample store holds
//   nothing defined until each entry is loaded. There is no clearing pass.
// ----------------------------------------------------------------------------
module window_threshold_classifier_top import wtc_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	wtc_item_if.sink      item,
	wtc_result_if.source  result,
	wtc_cfg_if.sink       cfg
);
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW    = CW + RW;
	localparam int DEPTH = 2 ** AW;

	cfg_t               cfg_regs;
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	wtc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.cfg    (cfg_regs)
	);

	wtc_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS),
		.AW         (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs),
		.item      (item),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	wtc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule

// ===== tb/window_threshold_classifier_top_test.sv =====
// ----------------------------------------------------------------------------
// window_threshold_classifier_top_test
// Self-checking bench for the window threshold classifier. Loads samples into
// the plane, classifies points whose in-grid window has been loaded, and
// checks every class beat against a behavioral copy of the classifier kept in
// a scoreboard. Runs directed corner cases, then random phases over several
// register settings with sender idling, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module window_threshold_classifier_top_test;
	import wtc_pkg::*;

	localparam int PLANE_W       = 256;
	localparam int PLANE_H       = 256;
	localparam int RADIUS_MAX    = 7;
	localparam int SETTLE_CYCLES = 240;
	localparam int HOLD_CYCLES   = 1500;
	localparam int CYCLE_LIMIT   = 3000000;

	typedef struct {
		point_class_t       point_class;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} class_beat_t;

	class class_scoreboard;
		logic [ENTRY_W-1:0] plane [PLANE_W*PLANE_H];
		cfg_t               regs;
		class_beat_t        expected_classes [$];
		int                 errors;

		function new();
			regs = '{lo_bound: 16'sd0, hi_bound: 16'sd32767, relax_radius: 3'd0,
				relax_min_count: 8'd1, true_if_centre_in_range: 1'b0,
				grid_width: 9'd256, grid_height: 9'd256};
			errors = 0;
		endfunction

		function bit in_limits(logic [SAMPLE_W-1:0] v);
			return $signed(v) >= $signed(regs.lo_bound) &&
				$signed(v) <= $signed(regs.hi_bound);
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_LO_BOUND:        regs.lo_bound = data;
				REG_HI_BOUND:        regs.hi_bound = data;
				REG_RELAX_RADIUS:    regs.relax_radius = data[RADIUS_W-1:0];
				REG_RELAX_MIN_COUNT: regs.relax_min_count = data[MIN_CNT_W-1:0];
				REG_CENTRE_OVERRIDE: regs.true_if_centre_in_range = data[0];
				REG_GRID_WIDTH:      regs.grid_width = data[GRID_W-1:0];
				REG_GRID_HEIGHT:     regs.grid_height = data[GRID_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(command_t cmd, logic [COORD_W-1:0] col,
				logic [COORD_W-1:0] row, logic [SAMPLE_W-1:0] sample, logic inv);
			int r, nx, ny, side, found, missing, c, rw;
			logic [ENTRY_W-1:0] e;
			class_beat_t beat;
			c = col;
			rw = row;
			if (cmd == CMD_LOAD) begin
				plane[rw*PLANE_W + c] = {inv, sample};
				return;
			end
			r = (regs.relax_radius > RADIUS_MAX) ? RADIUS_MAX : regs.relax_radius;
			nx = (regs.grid_width > PLANE_W) ? PLANE_W : regs.grid_width;
			ny = (regs.grid_height > PLANE_H) ? PLANE_H : regs.grid_height;
			side = 2*r + 1;
			found = 0;
			missing = 0;
			for (int x = c - r; x <= c + r; x++) begin
				for (int y = rw - r; y <= rw + r; y++) begin
					if (x >= 0 && x < nx && y >= 0 && y < ny) begin
						e = plane[y*PLANE_W + x];
						if (e[SAMPLE_W])
							missing++;
						else if (in_limits(e[SAMPLE_W-1:0]))
							found++;
					end else begin
						missing++;
					end
				end
			end
			beat.point_class = CLS_FALSE;
			if (found == side*side)
				beat.point_class = CLS_TRUE;
			else if (found >= int'(regs.relax_min_count))
				beat.point_class = CLS_RELAXED;
			if (missing == side*side)
				beat.point_class = CLS_MISSING;
			// override looks at the stored value, flag or not
			if (regs.true_if_centre_in_range && c < nx && rw < ny &&
					in_limits(plane[rw*PLANE_W + c][SAMPLE_W-1:0]))
				beat.point_class = CLS_TRUE;
			beat.col = col;
			beat.row = row;
			expected_classes.push_back(beat);
		endfunction

		function void check_result(point_class_t cls, logic [COORD_W-1:0] col,
				logic [COORD_W-1:0] row);
			class_beat_t want;
			if (expected_classes.size() == 0) begin
				$error("class beat at col %0d row %0d with no classify pending", col, row);
				errors++;
				return;
			end
			want = expected_classes.pop_front();
			if (cls !== want.point_class) begin
				$error("point_class expected %0d actual %0d", want.point_class, cls);
				errors++;
			end
			if (col !== want.col) begin
				$error("class_col expected %0d actual %0d", want.col, col);
				errors++;
			end
			if (row !== want.row) begin
				$error("class_row expected %0d actual %0d", want.row, row);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wtc_item_if   item_bus();
	wtc_result_if result_bus();
	wtc_cfg_if    cfg_bus();

	class_scoreboard sb;
	bit              loaded [PLANE_W*PLANE_H];
	cfg_t            drive_cfg;
	int              tx_idle_pct;
	int              rx_stall_pct;
	bit              hold_off_req;
	int              hold_count;
	int              cycle_count;
	int              items_sent;

	window_threshold_classifier_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: one long hold-off on request, then random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (hold_off_req && hold_count < HOLD_CYCLES) begin
			result_bus.ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready)
				sb.write_reg(cfg_idx_t'(cfg_bus.index), cfg_bus.data);
			if (item_bus.valid && item_bus.ready)
				sb.note_item(command_t'(item_bus.command), item_bus.col, item_bus.row,
					item_bus.sample, item_bus.sample_invalid);
			if (result_bus.valid && result_bus.ready)
				sb.check_result(point_class_t'(result_bus.point_class),
					result_bus.class_col, result_bus.class_row);
		end
	end

	function automatic int clip_coord(int v);
		return (v < 0) ? 0 : ((v > PLANE_W - 1) ? PLANE_W - 1 : v);
	endfunction

	function automatic logic [ENTRY_W-1:0] pick_entry();
		int lo, hi, roll;
		logic [SAMPLE_W-1:0] v;
		lo = $signed(drive_cfg.lo_bound);
		hi = $signed(drive_cfg.hi_bound);
		roll = $urandom_range(99);
		v = 16'($urandom);
		if (roll < 50 && lo <= hi) begin
			v = 16'(lo + int'($urandom_range(hi - lo)));
		end else if (roll < 62) begin
			case ($urandom_range(5))
				0: v = 16'(lo);
				1: v = 16'(hi);
				2: v = 16'(lo - 1);
				3: v = 16'(hi + 1);
				4: v = 16'h8000;
				default: v = 16'h7fff;
			endcase
		end
		return {1'($urandom_range(99) < 12), v};
	endfunction

	// in-grid window places not loaded yet
	function automatic int window_gaps(int col, int row);
		int r, nx, ny, n;
		r = drive_cfg.relax_radius;
		nx = (drive_cfg.grid_width > PLANE_W) ? PLANE_W : drive_cfg.grid_width;
		ny = (drive_cfg.grid_height > PLANE_H) ? PLANE_H : drive_cfg.grid_height;
		n = 0;
		for (int x = col - r; x <= col + r; x++)
			for (int y = row - r; y <= row + r; y++)
				if (x >= 0 && x < nx && y >= 0 && y < ny && !loaded[y*PLANE_W + x])
					n++;
		return n;
	endfunction

	task automatic send_item(command_t cmd, int col, int row, logic [SAMPLE_W-1:0] sample,
			logic inv);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.command <= cmd;
		item_bus.col <= 8'(col);
		item_bus.row <= 8'(row);
		item_bus.sample <= sample;
		item_bus.sample_invalid <= inv;
		do @(posedge clk); while (!item_bus.ready);
		if (cmd == CMD_LOAD)
			loaded[row*PLANE_W + col] = 1'b1;
		items_sent++;
	endtask

	task automatic fill_window(int col, int row);
		int r, nx, ny;
		logic [ENTRY_W-1:0] e;
		r = drive_cfg.relax_radius;
		nx = (drive_cfg.grid_width > PLANE_W) ? PLANE_W : drive_cfg.grid_width;
		ny = (drive_cfg.grid_height > PLANE_H) ? PLANE_H : drive_cfg.grid_height;
		for (int x = col - r; x <= col + r; x++) begin
			for (int y = row - r; y <= row + r; y++) begin
				if (x >= 0 && x < nx && y >= 0 && y < ny && !loaded[y*PLANE_W + x]) begin
					e = pick_entry();
					send_item(CMD_LOAD, x, y, e[SAMPLE_W-1:0], e[SAMPLE_W]);
				end
			end
		end
	endtask

	task automatic classify_point(int col, int row);
		fill_window(col, row);
		send_item(CMD_CLASSIFY, col, row, 16'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_classes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// unused upper data bits carry noise
	task automatic set_config(int lo, int hi, int r, int mn, int ovr, int gw, int gh);
		logic [CFG_DAT_W-1:0] junk;
		settle();
		junk = 16'($urandom);
		write_reg(REG_LO_BOUND, 16'(lo));
		write_reg(REG_HI_BOUND, 16'(hi));
		write_reg(REG_RELAX_RADIUS, {junk[15:3], 3'(r)});
		write_reg(REG_RELAX_MIN_COUNT, {junk[15:8], 8'(mn)});
		write_reg(REG_CENTRE_OVERRIDE, {junk[15:1], 1'(ovr)});
		write_reg(REG_GRID_WIDTH, {junk[15:9], 9'(gw)});
		write_reg(REG_GRID_HEIGHT, {junk[15:9], 9'(gh)});
		cfg_bus.valid <= 1'b0;
		drive_cfg.lo_bound = 16'(lo);
		drive_cfg.hi_bound = 16'(hi);
		drive_cfg.relax_radius = 3'(r);
		drive_cfg.relax_min_count = 8'(mn);
		drive_cfg.true_if_centre_in_range = 1'(ovr);
		drive_cfg.grid_width = 9'(gw);
		drive_cfg.grid_height = 9'(gh);
	endtask

	task automatic run_random(int hot_col, int hot_row, int span, int n);
		int start, r, col, row, c2, r2;
		logic [ENTRY_W-1:0] e;
		start = items_sent;
		r = drive_cfg.relax_radius;
		while (items_sent - start < n) begin
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(99) < 70) begin
					col = clip_coord(hot_col - r + int'($urandom_range(span - 1 + 2*r)));
					row = clip_coord(hot_row - r + int'($urandom_range(span - 1 + 2*r)));
				end else begin
					col = $urandom_range(PLANE_W - 1);
					row = $urandom_range(PLANE_H - 1);
				end
				e = pick_entry();
				send_item(CMD_LOAD, col, row, e[SAMPLE_W-1:0], e[SAMPLE_W]);
			end else begin
				col = clip_coord(hot_col + int'($urandom_range(span - 1)));
				row = clip_coord(hot_row + int'($urandom_range(span - 1)));
				if ($urandom_range(99) < 15) begin
					c2 = $urandom_range(PLANE_W - 1);
					r2 = $urandom_range(PLANE_H - 1);
					if (window_gaps(c2, r2) <= 40) begin
						col = c2;
						row = r2;
					end
				end
				classify_point(col, row);
			end
		end
	endtask

	initial begin
		item_bus.valid = 1'b0;
		item_bus.command = CMD_LOAD;
		item_bus.col = '0;
		item_bus.row = '0;
		item_bus.sample = '0;
		item_bus.sample_invalid = 1'b0;
		result_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_LO_BOUND;
		cfg_bus.data = '0;
		sb = new();
		drive_cfg = sb.regs;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		send_item(CMD_LOAD, 0, 0, 16'h8000, 1'b0);
		send_item(CMD_LOAD, 255, 255, 16'h7fff, 1'b0);
		send_item(CMD_LOAD, 1, 0, 16'h0000, 1'b0);
		send_item(CMD_LOAD, 0, 255, 16'h8000, 1'b1);
		send_item(CMD_LOAD, 255, 0, 16'h7fff, 1'b1);
		send_item(CMD_LOAD, 128, 127, 16'hffff, 1'b0);
		classify_point(0, 0);
		classify_point(255, 255);
		classify_point(1, 0);
		classify_point(0, 255);
		classify_point(255, 0);
		classify_point(128, 127);
		// override on an invalid centre
		set_config(-32768, 32767, 0, 1, 1, 256, 256);
		classify_point(0, 255);
		classify_point(255, 0);
		// crossed limits, tiny grid, centre off grid
		set_config(1, -1, 1, 0, 1, 2, 2);
		classify_point(1, 1);
		classify_point(200, 200);
		// zero-size grid
		set_config(0, 32767, 2, 0, 1, 0, 0);
		classify_point(0, 0);
		classify_point(255, 255);

		// random phases
		set_config(0, 32767, 0, 1, 0, 256, 256);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_off_req = 1'b1;
		run_random(0, 0, 16, 110);

		set_config(-32768, 32767, 7, 225, 0, 511, 511);
		tx_idle_pct = 56;
		rx_stall_pct = 0;
		run_random(253, 253, 3, 120);

		set_config(-1000, 1000, 2, 10, 1, 12, 9);
		tx_idle_pct = 0;
		rx_stall_pct = 56;
		run_random(0, 0, 14, 120);

		set_config(100, -100, 1, 0, 1, 256, 1);
		tx_idle_pct = 34;
		rx_stall_pct = 34;
		run_random(0, 0, 20, 110);

		set_config(32767, 32767, 3, 0, 0, 0, 0);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_random(120, 60, 8, 80);

		set_config(-32768, -32768, 4, 5, 0, 1, 256);
		tx_idle_pct = 56;
		rx_stall_pct = 0;
		run_random(0, 100, 4, 110);

		set_config(-20000, 20000, 7, 100, 1, 16, 12);
		tx_idle_pct = 0;
		rx_stall_pct = 56;
		run_random(0, 0, 18, 120);

		set_config(0, 0, 5, 1, 1, 200, 256);
		tx_idle_pct = 34;
		rx_stall_pct = 34;
		run_random(196, 251, 5, 110);

		settle();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
